// File: src/frw_pkg.sv
// shared types and constants for the fragment replay window
`default_nettype none

package frw_pkg;

    // fixed field widths
    localparam int SEQ_W  = 24;
    localparam int FRAG_W = 4;
    localparam int MAP_W  = 16;
    localparam int VERD_W = 2;

    // stream widths, padded to whole bytes
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 8;

    // verdict codes
    localparam logic [VERD_W-1:0] VERDICT_OK     = 2'd0;
    localparam logic [VERD_W-1:0] VERDICT_ARG    = 2'd1;
    localparam logic [VERD_W-1:0] VERDICT_REPLAY = 2'd2;
    localparam logic [VERD_W-1:0] VERDICT_DUP    = 2'd3;

    // one ring entry: tag names the sequence the bitmap belongs to
    typedef struct packed {
        logic             valid;
        logic [SEQ_W-1:0] tag;
        logic [MAP_W-1:0] bits;
    } entry_t;

endpackage

`default_nettype wire

// File: src/fragment_replay_window_unit.sv
// anti-replay sliding window with per-fragment bitmaps in a tagged ring memory
//
//  channel  | dir | handshake               | payload
//  ---------+-----+-------------------------+------------------------------------
//  s_       | in  | s_tvalid / s_tready     | s_tdata: seq_number, frag_index
//  m_       | out | m_tvalid / m_tready     | m_tdata: verdict
//
//  In the common case a frame passes through compare, window move with ring
//  read, bitmap check and write, and output load; a bad argument skips the move
//  and the check, a replay skips the check; the ring memory read-modify-write
//  sets these steps. After reset a clearing pass sweeps the ring, one entry a
//  cycle, with s_tready low.
//  One frame is in flight at a time; a stalled result holds the block in its
//  output step, while the next request is taken as soon as the result is loaded.
`default_nettype none

module fragment_replay_window_unit #(
    parameter int WINDOW_DEPTH   = 64,
    parameter int FRAGMENT_SLOTS = 16,
    parameter int SEQ_BITS       = 24
) (
    input  wire                           aclk,
    input  wire                           aresetn,
    // request channel
    input  wire                           s_tvalid,
    output logic                          s_tready,
    input  wire  [frw_pkg::S_DATA_W-1:0]  s_tdata,   // [23:0] seq_number, [27:24] frag_index
    // result channel
    output logic                          m_tvalid,
    input  wire                           m_tready,
    output logic [frw_pkg::M_DATA_W-1:0]  m_tdata    // [1:0] verdict
);

    import frw_pkg::*;

    localparam int IDX_W   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int SEQ_CHK = (SEQ_BITS < SEQ_W) ? SEQ_BITS : SEQ_W;

    localparam logic [IDX_W:0]    DEPTH_X    = (IDX_W+1)'(WINDOW_DEPTH);
    localparam logic [SEQ_W-1:0]  DEPTH_S    = SEQ_W'(WINDOW_DEPTH);
    localparam logic [IDX_W-1:0]  LAST_IDX   = IDX_W'(WINDOW_DEPTH - 1);
    localparam logic [FRAG_W:0]   SLOTS_X    = (FRAG_W+1)'(FRAGMENT_SLOTS);

    // sequencer states
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_CALC  = 3'd2;
    localparam logic [2:0] S_MOVE  = 3'd3;
    localparam logic [2:0] S_CHECK = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]        state_reg,   state_next;
    logic [IDX_W-1:0]  clr_idx_reg, clr_idx_next;
    logic [SEQ_W-1:0]  seq_reg,     seq_next;
    logic [FRAG_W-1:0] frag_reg,    frag_next;
    logic              started_reg, started_next;
    logic [SEQ_W-1:0]  top_reg,     top_next;
    logic [IDX_W-1:0]  head_reg,    head_next;
    logic              gt_reg,      gt_next;
    logic [SEQ_W-1:0]  up_reg,      up_next;
    logic [SEQ_W-1:0]  dn_reg,      dn_next;
    logic [IDX_W-1:0]  addr_reg,    addr_next;
    logic [VERD_W-1:0] verdict_reg, verdict_next;
    logic              m_valid_reg, m_valid_next;
    logic [VERD_W-1:0] m_verd_reg,  m_verd_next;

    // ring memory
    entry_t            ring [WINDOW_DEPTH];
    entry_t            rd_data_reg;
    logic              rd_en;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    entry_t            wr_data;

    // datapath helpers
    logic              seq_bad;
    logic              frag_bad;
    logic [IDX_W:0]    head_sum;
    logic [IDX_W-1:0]  head_adv;
    logic [IDX_W:0]    back_sum;
    logic [IDX_W-1:0]  back_idx;
    logic              far_up;
    logic              replay;
    logic              hit;
    logic [MAP_W-1:0]  old_bits;
    logic [MAP_W-1:0]  bit_mask;

    // argument checks on the held request
    assign seq_bad  = (SEQ_BITS < SEQ_W) && ((seq_reg >> SEQ_CHK) != '0);
    assign frag_bad = {1'b0, frag_reg} >= SLOTS_X;

    // head pointer moved forward by a short slide
    assign head_sum = {1'b0, head_reg} + {1'b0, up_reg[IDX_W-1:0]};
    assign head_adv = (head_sum >= DEPTH_X) ? IDX_W'(head_sum - DEPTH_X) : head_sum[IDX_W-1:0];
    assign far_up   = up_reg >= DEPTH_S;

    // ring slot of an older sequence, wrapped below zero
    assign back_sum = (head_reg >= dn_reg[IDX_W-1:0])
                    ? ({1'b0, head_reg} - {1'b0, dn_reg[IDX_W-1:0]})
                    : ({1'b0, head_reg} + DEPTH_X - {1'b0, dn_reg[IDX_W-1:0]});
    assign back_idx = back_sum[IDX_W-1:0];
    assign replay   = dn_reg >= DEPTH_S;

    // bitmap lookup on the registered ring word
    assign hit      = rd_data_reg.valid && (rd_data_reg.tag == seq_reg);
    assign old_bits = hit ? rd_data_reg.bits : '0;
    assign bit_mask = MAP_W'(1) << frag_reg;

    // sequencer
    always_comb begin
        state_next   = state_reg;
        clr_idx_next = clr_idx_reg;
        seq_next     = seq_reg;
        frag_next    = frag_reg;
        started_next = started_reg;
        top_next     = top_reg;
        head_next    = head_reg;
        gt_next      = gt_reg;
        up_next      = up_reg;
        dn_next      = dn_reg;
        addr_next    = addr_reg;
        verdict_next = verdict_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_verd_next  = m_verd_reg;
        rd_en        = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = addr_reg;
        wr_data      = '0;

        unique case (state_reg)
            S_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = clr_idx_reg;
                if (clr_idx_reg == LAST_IDX) begin
                    state_next = S_IDLE;
                end else begin
                    clr_idx_next = clr_idx_reg + 1'b1;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    seq_next   = s_tdata[SEQ_W-1:0];
                    frag_next  = s_tdata[SEQ_W +: FRAG_W];
                    state_next = S_CALC;
                end
            end
            S_CALC: begin
                gt_next = !started_reg || (seq_reg > top_reg);
                up_next = seq_reg - top_reg;
                dn_next = top_reg - seq_reg;
                if (seq_bad || frag_bad) begin
                    verdict_next = VERDICT_ARG;
                    state_next   = S_OUT;
                end else begin
                    state_next = S_MOVE;
                end
            end
            S_MOVE: begin
                if (!started_reg) begin
                    started_next = 1'b1;
                    top_next     = seq_reg;
                    addr_next    = head_reg;
                    rd_en        = 1'b1;
                    state_next   = S_CHECK;
                end else if (gt_reg) begin
                    top_next = seq_reg;
                    if (far_up) begin
                        addr_next = head_reg;
                    end else begin
                        head_next = head_adv;
                        addr_next = head_adv;
                    end
                    rd_en      = 1'b1;
                    state_next = S_CHECK;
                end else if (replay) begin
                    verdict_next = VERDICT_REPLAY;
                    state_next   = S_OUT;
                end else begin
                    addr_next  = back_idx;
                    rd_en      = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if ((old_bits & bit_mask) != '0) begin
                    verdict_next = VERDICT_DUP;
                end else begin
                    wr_en        = 1'b1;
                    wr_data      = '{valid: 1'b1, tag: seq_reg, bits: old_bits | bit_mask};
                    verdict_next = VERDICT_OK;
                end
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_verd_next  = verdict_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control and payload registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_idx_reg <= '0;
            started_reg <= 1'b0;
            top_reg     <= '0;
            head_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_idx_reg <= clr_idx_next;
            started_reg <= started_next;
            top_reg     <= top_next;
            head_reg    <= head_next;
            m_valid_reg <= m_valid_next;
        end
        seq_reg     <= seq_next;
        frag_reg    <= frag_next;
        gt_reg      <= gt_next;
        up_reg      <= up_next;
        dn_reg      <= dn_next;
        addr_reg    <= addr_next;
        verdict_reg <= verdict_next;
        m_verd_reg  <= m_verd_next;
    end

    // ring write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            ring[wr_addr] <= wr_data;
        end
    end

    // ring read port, registered
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= ring[addr_next];
        end
    end

    // port drive
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_DATA_W-VERD_W){1'b0}}, m_verd_reg};

`ifndef SYNTHESIS
    // a taken request always starts the compare step
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == S_CALC))
        else $error("request not followed by compare step");

    // the bitmap check only runs once the window holds a top sequence
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CHECK) |-> started_reg)
        else $error("bitmap check before window start");

    // ring addresses stay inside the window depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CHECK) |-> ({1'b0, addr_reg} < DEPTH_X))
        else $error("ring address out of range");

    // no result loaded while the clearing pass runs
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLEAR) |=> !$rose(m_valid_reg))
        else $error("result raised during clearing pass");
`endif

endmodule

`default_nettype wire

// File: tb/fragment_replay_window_unit_test.sv
// self-checking testbench for the fragment replay window: directed and random request streams
`default_nettype none

module fragment_replay_window_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import frw_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int WINDOW_DEPTH   = 64;
    localparam int FRAGMENT_SLOTS = 16;
    localparam int SEQ_TOP        = 24'hFFFFFF;
    localparam int MAX_WAIT       = 12;
    localparam int EPOCHS         = 12;
    localparam int EPOCH_FRAMES   = 128;
    localparam int REPORT_LIMIT   = 10;
    localparam int CYCLE_LIMIT    = 400000;

    typedef struct {
        logic [SEQ_W-1:0]  seq;
        logic [FRAG_W-1:0] frag;
        logic [VERD_W-1:0] verdict;
    } frame_result_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;

    // window model kept alongside the block
    logic                  window_started;
    logic [SEQ_W-1:0]      top_sequence;
    logic [MAP_W-1:0]      seen_maps [WINDOW_DEPTH];

    frame_result_t         pending_verdicts[$];
    frame_result_t         recent_frames[$];
    int                    failure_count = 0;
    int                    cycle_count = 0;
    bit                    no_idle;

    fragment_replay_window_unit #(
        .WINDOW_DEPTH   (WINDOW_DEPTH),
        .FRAGMENT_SLOTS (FRAGMENT_SLOTS),
        .SEQ_BITS       (SEQ_W)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // clock
    initial aclk = 1'b0;
    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** fragment_replay_window_unit: FAILED **");
            $finish;
        end
    end

    // verdict of one frame, updating the window model
    function automatic logic [VERD_W-1:0] judge_frame(input logic [SEQ_W-1:0] seq,
                                                      input logic [FRAG_W-1:0] frag);
        int shift;
        int age;
        if (int'(frag) >= FRAGMENT_SLOTS)
            return VERDICT_ARG;
        if (!window_started) begin
            window_started = 1'b1;
            top_sequence   = seq;
        end else if (seq > top_sequence) begin
            shift = int'(seq) - int'(top_sequence);
            for (int k = WINDOW_DEPTH - 1; k >= 0; k--)
                seen_maps[k] = (shift < WINDOW_DEPTH && k >= shift) ? seen_maps[k - shift] : '0;
            top_sequence = seq;
        end
        age = int'(top_sequence) - int'(seq);
        if (age >= WINDOW_DEPTH)
            return VERDICT_REPLAY;
        if (seen_maps[age][frag])
            return VERDICT_DUP;
        seen_maps[age][frag] = 1'b1;
        return VERDICT_OK;
    endfunction

    function automatic int pick_wait();
        return no_idle ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    // one request: optional gap, then hold until taken
    task automatic send_frame(input logic [SEQ_W-1:0] seq, input logic [FRAG_W-1:0] frag);
        int            gap;
        frame_result_t want;
        gap = pick_wait();
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_DATA_W - SEQ_W - FRAG_W){1'b0}}, frag, seq};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        want.seq     = seq;
        want.frag    = frag;
        want.verdict = judge_frame(seq, frag);
        pending_verdicts.push_back(want);
        recent_frames.push_back(want);
        if (recent_frames.size() > 8)
            void'(recent_frames.pop_front());
    endtask

    // result side stalls
    initial begin : result_stalls
        int stall;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            stall = pick_wait();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!(m_tvalid && m_tready)) @(posedge aclk);
        end
    end

    // compare every result with the oldest expected verdict
    always @(posedge aclk) begin : check_results
        frame_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_verdicts.size() == 0) begin
                failure_count++;
                if (failure_count <= REPORT_LIMIT)
                    $display("unexpected result verdict=%0d at cycle %0d",
                             m_tdata[VERD_W-1:0], cycle_count);
            end else begin
                want = pending_verdicts.pop_front();
                if (m_tdata[VERD_W-1:0] !== want.verdict) begin
                    failure_count++;
                    if (failure_count <= REPORT_LIMIT)
                        $display("seq=%06h frag=%0d: verdict expected %0d, got %0d",
                                 want.seq, want.frag, want.verdict, m_tdata[VERD_W-1:0]);
                end
            end
        end
    end

    // first frame opens the window, fragment extremes and duplicates
    task automatic test_first_frames();
        send_frame(24'd0, 4'd0);
        send_frame(24'd0, 4'd15);
        send_frame(24'd0, 4'd0);
        send_frame(24'd0, 4'd15);
        send_frame(24'd0, 4'd5);
    endtask

    // oldest slot of the window and the first sequence past it
    task automatic test_window_boundary();
        send_frame(24'd63, 4'd1);
        send_frame(24'd0, 4'd0);
        send_frame(24'd0, 4'd1);
        send_frame(24'd64, 4'd2);
        send_frame(24'd0, 4'd2);
        send_frame(24'd1, 4'd1);
        // lower sequence leaves the window where it is
        send_frame(24'd30, 4'd7);
        send_frame(24'd30, 4'd7);
    endtask

    // slides just inside the depth keep history, a full-depth jump clears it
    task automatic test_slide_and_jump();
        send_frame(24'd1000, 4'd9);
        send_frame(24'd937, 4'd0);
        send_frame(24'd936, 4'd0);
        send_frame(24'd1063, 4'd4);
        send_frame(24'd1000, 4'd9);
        send_frame(24'd1127, 4'd4);
        send_frame(24'd1063, 4'd4);
        send_frame(24'd1064, 4'd4);
    endtask

    // epochs of plausible traffic around a rising top, with noise
    task automatic test_random_traffic();
        int            pick;
        int unsigned   top;
        int unsigned   seq;
        int unsigned   off;
        frame_result_t old;
        for (int e = 1; e <= EPOCHS; e++) begin
            no_idle = (e % 4 == 0);
            send_frame(SEQ_W'(e * 32'h140000 + $urandom_range(0, 16'hFFFF)),
                       FRAG_W'($urandom_range(0, 15)));
            for (int n = 1; n < EPOCH_FRAMES; n++) begin
                pick = $urandom_range(0, 99);
                top  = top_sequence;
                if (pick < 35) begin
                    off = $urandom_range(0, WINDOW_DEPTH - 1);
                    seq = (top >= off) ? top - off : 0;
                end else if (pick < 55) begin
                    seq = top + $urandom_range(1, 3);
                end else if (pick < 70 && recent_frames.size() > 0) begin
                    // replay a recent frame, mostly a duplicate
                    old = recent_frames[$urandom_range(0, recent_frames.size() - 1)];
                    send_frame(old.seq, old.frag);
                    continue;
                end else if (pick < 80) begin
                    off = $urandom_range(WINDOW_DEPTH - 4, WINDOW_DEPTH + 6);
                    seq = (top >= off) ? top - off : 0;
                end else if (pick < 88) begin
                    seq = top + $urandom_range(WINDOW_DEPTH - 24, WINDOW_DEPTH + 36);
                end else begin
                    seq = $urandom_range(0, top);
                end
                send_frame(SEQ_W'(seq), FRAG_W'($urandom_range(0, 15)));
            end
        end
        no_idle = 1'b0;
    endtask

    // highest sequence number, far-below replay with no wrap
    task automatic test_sequence_extremes();
        send_frame(SEQ_W'(SEQ_TOP), 4'd15);
        send_frame(SEQ_W'(SEQ_TOP), 4'd15);
        send_frame(24'd0, 4'd0);
        send_frame(SEQ_W'(SEQ_TOP - 63), 4'd3);
        send_frame(SEQ_W'(SEQ_TOP - 64), 4'd3);
    endtask

    initial begin
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        no_idle        = 1'b0;
        window_started = 1'b0;
        top_sequence   = '0;
        foreach (seen_maps[k]) seen_maps[k] = '0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_first_frames();
        test_window_boundary();
        test_slide_and_jump();
        test_random_traffic();
        test_sequence_extremes();

        // drain outstanding results, then watch for stray ones
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        if (failure_count == 0) begin
            $display("** fragment_replay_window_unit: PASSED **");
        end else begin
            $display("** fragment_replay_window_unit: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
src/frw_pkg.sv
src/fragment_replay_window_unit.sv
tb/fragment_replay_window_unit_test.sv
